>>> hw/rtl/tdvs_pkg.sv
// ----------------------------------------------------------------------------
// tdvs_pkg
// Types and constants shared by the target direction velocity sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tdvs_pkg;

    localparam int NUM_AXES   = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    localparam int ST_JITTER  = 0;
    localparam int ST_ABS     = 1;
    localparam int ST_LEN     = 2;
    localparam int ST_SHIFT   = 3;
    localparam int ST_SQUARE  = 4;
    localparam int ST_SUM     = 5;
    localparam int ST_SQRT0   = 6;
    localparam int ST_DIV0    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_PART    = ST_DIV0 + DIV_STEPS;
    localparam int ST_ADD     = ST_PART + 1;
    localparam int ST_SAT     = ST_ADD + 1;
    localparam int NUM_STAGES = ST_SAT + 1;

    localparam logic [2:0] REG_TARGET_X  = 3'd0;
    localparam logic [2:0] REG_TARGET_Y  = 3'd1;
    localparam logic [2:0] REG_TARGET_Z  = 3'd2;
    localparam logic [2:0] REG_SPREAD_X  = 3'd3;
    localparam logic [2:0] REG_SPREAD_Y  = 3'd4;
    localparam logic [2:0] REG_SPREAD_Z  = 3'd5;
    localparam logic [2:0] REG_NORMALIZE = 3'd6;
    localparam logic [2:0] REG_MAGNITUDE = 3'd7;

    localparam logic [63:0] MAG_RESET = 64'd65536;
    localparam int          UNIT_LEN  = 31;

    typedef struct packed {
        logic                  nrm;
        logic [2:0]            vs;
        logic                  ms;
        logic [2:0][35:0]      vj;
        logic [35:0]           mj;
        logic [2:0][35:0]      va;
        logic [35:0]           ma;
        logic [35:0]           mx;
        logic                  shr;
        logic [4:0]            sh;
        logic [2:0][30:0]      na;
        logic [2:0][61:0]      sq;
        logic [63:0]           sn;
        logic [35:0]           srem;
        logic [31:0]           sroot;
        logic [2:0][48:0]      drem;
        logic [2:0][16:0]      dq;
        logic [2:0][51:0]      pp1;
        logic [2:0][37:0]      pp2;
        logic [2:0][37:0]      pp3;
        logic [2:0][71:0]      prod;
        logic [2:0][31:0]      vel;
    } pipe_t;

endpackage

`default_nettype wire

>>> hw/rtl/target_direction_velocity_sample.sv
// ----------------------------------------------------------------------------
// target_direction_velocity_sample
// Per-particle velocity toward a jittered target, optionally unit length,
// scaled by a randomized magnitude.
//
// Input stream carries one particle request: start position and four random
// fractions. Output stream returns one velocity request per input request.
// Stages: jitter, abs/max, length detect, shift, squares, sum, 32 square
// root steps, 17 divide steps (three lanes), two product stages and
// saturation. One request enters every cycle; the square root and divider
// are fully unrolled into one register stage per digit. Each stage holds
// while the stage after it is full and stalled, and empty stages keep
// filling, so a stalled receiver fills the pipe before s_tready drops. The
// user must write configuration registers (cfg_we / cfg_index / cfg_wdata)
// only while the pipe is empty; the block does not enforce it. Reset clears
// all valid bits and sets target 0, spread 0, normalize off, magnitude 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module target_direction_velocity_sample (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_z, rand_x, rand_y, rand_z, rand_mag
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // vel_x, vel_y, vel_z
    output logic [95:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata
);
    import tdvs_pkg::*;

    logic [31:0] target_reg [NUM_AXES];
    logic [30:0] spread_reg [NUM_AXES];
    logic        normalize_reg;
    logic [63:0] mag_reg;

    pipe_t s0_next;
    pipe_t pl_reg  [NUM_STAGES];
    pipe_t pl_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                target_reg[i] <= '0;
                spread_reg[i] <= '0;
            end
            normalize_reg <= 1'b0;
            mag_reg       <= MAG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TARGET_X:  target_reg[0] <= cfg_wdata[31:0];
                REG_TARGET_Y:  target_reg[1] <= cfg_wdata[31:0];
                REG_TARGET_Z:  target_reg[2] <= cfg_wdata[31:0];
                REG_SPREAD_X:  spread_reg[0] <= cfg_wdata[30:0];
                REG_SPREAD_Y:  spread_reg[1] <= cfg_wdata[30:0];
                REG_SPREAD_Z:  spread_reg[2] <= cfg_wdata[30:0];
                REG_NORMALIZE: normalize_reg <= cfg_wdata[0];
                REG_MAGNITUDE: mag_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        en[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    // jitter and magnitude
    always_comb begin
        logic [46:0] jp;
        logic [47:0] mp;
        s0_next = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            jp = 47'(s_tdata[96+16*i +: 16]) * 47'(spread_reg[i]);
            s0_next.vj[i] = 36'(signed'(target_reg[i]))
                          - 36'(signed'(s_tdata[32*i +: 32]))
                          - 36'(spread_reg[i])
                          + 36'(jp[46:15]);
        end
        mp = 48'(s_tdata[159:144]) * 48'(mag_reg[63:32]);
        s0_next.mj  = 36'(signed'(mag_reg[31:0])) - 36'(mag_reg[63:32]) + 36'(mp[47:15]);
        s0_next.nrm = normalize_reg;
    end

    always_comb begin
        pipe_t       p;
        logic [5:0]  blen;
        logic [35:0] rem_t;
        logic [35:0] trial;
        logic [48:0] dd;
        logic [35:0] av;
        logic        neg;
        pl_next[0] = s0_next;
        for (int k = 1; k < NUM_STAGES; k++) begin
            p     = pl_reg[k-1];
            blen  = '0;
            rem_t = '0;
            trial = '0;
            dd    = '0;
            av    = '0;
            neg   = 1'b0;
            if (k == ST_ABS) begin
                p.mx = '0;
                for (int i = 0; i < NUM_AXES; i++) begin
                    p.vs[i] = p.vj[i][35];
                    p.va[i] = p.vj[i][35] ? 36'(-p.vj[i]) : p.vj[i];
                    if (p.va[i] > p.mx) begin
                        p.mx = p.va[i];
                    end
                end
                p.ms  = p.mj[35];
                p.ma  = p.mj[35] ? 36'(-p.mj) : p.mj;
                p.nrm = p.nrm && (p.mx != '0);
            end else if (k == ST_LEN) begin
                for (int b = 0; b < 36; b++) begin
                    if (p.mx[b]) begin
                        blen = 6'(b + 1);
                    end
                end
                p.shr = blen > 6'(UNIT_LEN);
                p.sh  = p.shr ? 5'(blen - 6'(UNIT_LEN)) : 5'(6'(UNIT_LEN) - blen);
            end else if (k == ST_SHIFT) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    p.na[i] = p.shr ? 31'(p.va[i] >> p.sh) : 31'(p.va[i] << p.sh);
                end
            end else if (k == ST_SQUARE) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    p.sq[i] = 62'(p.na[i]) * 62'(p.na[i]);
                end
            end else if (k == ST_SUM) begin
                p.sn    = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
                p.srem  = '0;
                p.sroot = '0;
            end else if (k >= ST_SQRT0 && k < ST_DIV0) begin
                rem_t = {p.srem[33:0], p.sn[63:62]};
                trial = {2'b00, p.sroot, 2'b01};
                if (rem_t >= trial) begin
                    p.srem  = rem_t - trial;
                    p.sroot = {p.sroot[30:0], 1'b1};
                end else begin
                    p.srem  = rem_t;
                    p.sroot = {p.sroot[30:0], 1'b0};
                end
                p.sn = {p.sn[61:0], 2'b00};
            end else if (k >= ST_DIV0 && k < ST_PART) begin
                dd = 49'(p.sroot) << (ST_PART - 1 - k);
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (k == ST_DIV0) begin
                        p.drem[i] = {2'b00, p.na[i], 16'h0000};
                        p.dq[i]   = '0;
                    end
                    if (p.drem[i] >= dd) begin
                        p.drem[i] = p.drem[i] - dd;
                        p.dq[i][ST_PART - 1 - k] = 1'b1;
                    end
                end
            end else if (k == ST_PART) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    av       = p.nrm ? 36'(p.dq[i]) : p.va[i];
                    p.pp1[i] = 52'(av) * 52'(p.ma[15:0]);
                    p.pp2[i] = 38'(av[17:0]) * 38'(p.ma[35:16]);
                    p.pp3[i] = 38'(av[35:18]) * 38'(p.ma[35:16]);
                end
            end else if (k == ST_ADD) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    p.prod[i] = (72'(p.pp3[i]) << 18) + 72'(p.pp2[i]) + 72'(p.pp1[i] >> 16);
                end
            end else begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    neg = p.vs[i] ^ p.ms;
                    if (neg) begin
                        p.vel[i] = (p.prod[i] > 72'h80000000) ? 32'h80000000
                                                              : 32'(-p.prod[i]);
                    end else begin
                        p.vel[i] = (p.prod[i] > 72'h7FFFFFFF) ? 32'h7FFFFFFF
                                                              : p.prod[i][31:0];
                    end
                end
            end
            pl_next[k] = p;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                pl_reg[k] <= pl_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {pl_reg[NUM_STAGES-1].vel[2], pl_reg[NUM_STAGES-1].vel[1],
                       pl_reg[NUM_STAGES-1].vel[0]};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid right after reset");

    a_empty_head_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_tready) else $error("empty head stage refused a request");

    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/tdvs_checker.sv
// ----------------------------------------------------------------------------
// tdvs_checker
// Watches both streams of the target direction velocity sampler, predicts
// each velocity from the particle request and the current register set, and
// compares the result requests in order. Reports the failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tdvs_checker
    import tdvs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [159:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [95:0]  m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                vel_seen,
    output int                sat_seen,
    output int                zero_norm_seen
);

    logic [31:0] tgt [3];
    logic [30:0] spr [3];
    logic        nrm_en;
    logic [63:0] mag_pair;
    logic [95:0] vel_fifo [$];

    function automatic logic [63:0] abs64(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] scale_sat(input longint v, input longint m);
        logic [63:0] av;
        logic [63:0] am;
        logic [63:0] p;
        av = abs64(v);
        am = abs64(m);
        p = av * (am >> 16) + ((av * am[15:0]) >> 16);
        if ((v < 0) != (m < 0))
            return p > 64'h8000_0000 ? 32'h8000_0000 : 32'(-p);
        return p > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : p[31:0];
    endfunction

    function automatic logic [95:0] velocity_of(input logic [159:0] d);
        longint      v [3];
        logic [63:0] a [3];
        logic [63:0] mx;
        logic [63:0] r;
        logic [63:0] add;
        logic [63:0] var_q;
        longint      m;
        logic [95:0] res;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            add = (64'(d[96+16*i +: 16]) * spr[i] * 2) >> 16;
            v[i] = longint'($signed(tgt[i])) - longint'($signed(d[32*i +: 32]))
                 - longint'(spr[i]) + longint'(add);
            a[i] = abs64(v[i]);
            if (a[i] > mx) mx = a[i];
        end
        if (nrm_en && mx != 0) begin
            while (mx >= 64'h8000_0000) begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) a[i] >>= 1;
            end
            while (mx < 64'h4000_0000) begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) a[i] <<= 1;
            end
            r = root64(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            for (int i = 0; i < 3; i++)
                v[i] = v[i] < 0 ? -longint'((a[i] << 16) / r) : longint'((a[i] << 16) / r);
        end
        var_q = 64'(mag_pair[63:32]);
        m = longint'($signed(mag_pair[31:0])) - longint'(var_q)
          + longint'((64'(d[159:144]) * var_q * 2) >> 16);
        for (int i = 0; i < 3; i++) res[32*i +: 32] = scale_sat(v[i], m);
        return res;
    endfunction

    assign pending = vel_fifo.size();

    always @(posedge aclk) begin
        logic [95:0] exp_vel;
        int          nsat;
        int          nfail;
        nsat  = 0;
        nfail = 0;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                tgt[i] <= '0;
                spr[i] <= '0;
            end
            nrm_en   <= 1'b0;
            mag_pair <= MAG_RESET;
            fail_count <= 0;
            vel_seen <= 0;
            sat_seen <= 0;
            zero_norm_seen <= 0;
            vel_fifo.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_X:  tgt[0] <= cfg_wdata[31:0];
                    REG_TARGET_Y:  tgt[1] <= cfg_wdata[31:0];
                    REG_TARGET_Z:  tgt[2] <= cfg_wdata[31:0];
                    REG_SPREAD_X:  spr[0] <= cfg_wdata[30:0];
                    REG_SPREAD_Y:  spr[1] <= cfg_wdata[30:0];
                    REG_SPREAD_Z:  spr[2] <= cfg_wdata[30:0];
                    REG_NORMALIZE: nrm_en <= cfg_wdata[0];
                    REG_MAGNITUDE: mag_pair <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                exp_vel = velocity_of(s_tdata);
                vel_fifo.push_back(exp_vel);
                if (nrm_en && exp_vel == '0) zero_norm_seen <= zero_norm_seen + 1;
                for (int i = 0; i < 3; i++)
                    if (exp_vel[32*i +: 32] == 32'h7FFF_FFFF
                        || exp_vel[32*i +: 32] == 32'h8000_0000)
                        nsat++;
            end
            if (m_tvalid && m_tready) begin
                vel_seen <= vel_seen + 1;
                if (vel_fifo.size() == 0) begin
                    $display("%0t: unexpected velocity request, expected none, got %h",
                             $time, m_tdata);
                    nfail++;
                end else begin
                    exp_vel = vel_fifo.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (m_tdata[32*i +: 32] !== exp_vel[32*i +: 32]) begin
                            $display("%0t: vel axis %0d mismatch, expected %h, got %h",
                                     $time, i, exp_vel[32*i +: 32], m_tdata[32*i +: 32]);
                            nfail++;
                        end
                end
            end
            sat_seen   <= sat_seen + nsat;
            fail_count <= fail_count + nfail;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives particle requests and register writes into the target direction
// velocity sampler with random gaps and stalls; the checker judges results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tdvs_pkg::*;

    localparam int PIPE_LAT = 70;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = REG_TARGET_X;
    logic [63:0]  cfg_wdata = '0;
    int           fail_count;
    int           pending;
    int           vel_seen;
    int           sat_seen;
    int           zero_norm_seen;
    logic         drain_done = 1'b0;
    int           stall_left = 0;

    always #2 aclk = ~aclk;

    target_direction_velocity_sample u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata
    );

    tdvs_checker u_chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata,
        .fail_count, .pending, .vel_seen, .sat_seen, .zero_norm_seen
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // hold m_tready low for random stretches; some phases never stall
    always @(posedge aclk) begin
        if (!aresetn || drain_done) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if ((vel_seen / 200) % 3 == 1) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= gap_len();
        end
    end

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [159:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_cfg(input int kind);
        for (int i = 0; i < 3; i++) begin
            write_reg(3'(REG_TARGET_X + i), kind == 0 ? 64'h8000_0000 :
                      kind == 1 ? 64'hFFFF_FFFF_7FFF_FFFF : {$urandom, $urandom});
            write_reg(3'(REG_SPREAD_X + i), kind == 0 ? 64'h0 :
                      kind == 1 ? 64'hFFFF_FFFF_FFFF_FFFF :
                      64'($urandom_range(0, 32'h0004_0000)));
        end
        write_reg(REG_NORMALIZE, {$urandom, $urandom});
        write_reg(REG_MAGNITUDE, kind == 0 ? 64'h0000_0000_8000_0000 :
                  kind == 1 ? 64'hFFFF_FFFF_7FFF_FFFF :
                  {32'($urandom_range(0, 32'h0002_0000)),
                   32'($signed($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000)});
    endtask

    logic [159:0] d;

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // defaults: exact vector, magnitude one
        send('0);
        send({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        send({16'h0, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000});
        idle_wait();
        write_reg(REG_NORMALIZE, 64'h1);
        send('0);
        send({64'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
        send({64'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        idle_wait();
        write_reg(REG_MAGNITUDE, 64'hFFFF_FFFF_7FFF_FFFF);
        write_reg(REG_SPREAD_X, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send({$urandom, $urandom, $urandom, $urandom, $urandom});
        idle_wait();
        for (int ph = 0; ph < 12; ph++) begin
            random_cfg(ph < 2 ? ph : 2);
            for (int k = 0; k < 90; k++) begin
                d = {$urandom, $urandom, rand_pos(), rand_pos(), rand_pos()};
                if ($urandom_range(0, 9) == 0) d[159:96] = '0;
                if ($urandom_range(0, 9) == 0) d[159:96] = '1;
                send(d);
            end
            idle_wait();
        end
        drain_done <= 1'b1;
        repeat (PIPE_LAT) @(posedge aclk);
        $display("Covered %0d velocity requests over 15 register settings, normalize on/off;",
                 vel_seen);
        $display("%0d saturated axes, %0d zero vectors under normalize.",
                 sat_seen, zero_norm_seen);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
